@@ hw/rtl/tlvp_pkg.sv @@
// Shared types, codes and constants of the TLV varint length parser.
`default_nettype none

package tlvp_pkg;

  // Default width of buffer offsets and counts.
  localparam int SIZE_BITS_DEF = 16;

  // Configuration port shape.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUFFER_SIZE = 1'b0,
    REG_MATCH_TAG   = 1'b1
  } cfg_reg_t;

  // Role of one byte within the buffer.
  typedef enum logic [2:0] {
    ROLE_TAG     = 3'd0,
    ROLE_LEN     = 3'd1,
    ROLE_VALUE   = 3'd2,
    ROLE_PAD     = 3'd3,
    ROLE_IGNORED = 3'd4
  } role_t;

  // Parse status reported with every result item.
  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_END      = 3'd1,
    ST_PAD_END  = 3'd2,
    ST_BAD_LEN  = 3'd3,
    ST_OVERRUN  = 3'd4
  } status_t;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_TAG  = 2'd0,
    PH_LEN  = 2'd1,
    PH_VAL  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  // Length byte fields.
  localparam logic [7:0] LEN_DATA_MASK = 8'h7F;
  localparam logic [7:0] LEN_MORE_BIT  = 8'h80;

  // One input item.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_buffer;
  } src_item_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  record_tag;
    logic [31:0] record_length;
    logic [7:0]  value_byte;
    logic [15:0] value_index;
    logic        record_done;
    logic        first_match_res;
    logic [2:0]  parse_status;
  } res_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/tlvp_in_stage.sv @@
// Input register stage: holds one accepted item until the parser takes it.
`default_nettype none

module tlvp_in_stage (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 src_valid,
  output logic                src_stall,
  input  tlvp_pkg::src_item_t src_item,
  input  wire                 advance_ok,
  output logic                step,
  output tlvp_pkg::src_item_t held_item
);
  import tlvp_pkg::*;

  logic full;

  // The held item moves on whenever the result register can load.
  assign step      = full && advance_ok;
  assign src_stall = full && !advance_ok;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (src_valid && !src_stall) begin
      full <= 1'b1;
    end else if (step) begin
      full <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (src_valid && !src_stall) begin
      held_item <= src_item;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tlvp_parse_core.sv @@
// Parser state and the per-byte record splitting logic.
`default_nettype none

module tlvp_parse_core #(
  parameter int SIZE_BITS = tlvp_pkg::SIZE_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 step,
  input  tlvp_pkg::src_item_t item,
  input  wire [SIZE_BITS-1:0] buffer_size,
  input  wire [7:0]           match_tag,
  output tlvp_pkg::res_item_t result
);
  import tlvp_pkg::*;

  // Parser state.
  phase_t               parse_phase, parse_phase_next;
  logic [SIZE_BITS-1:0] byte_offset, byte_offset_next;
  logic [7:0]           current_tag, current_tag_next;
  logic [31:0]          length_accumulator, length_accumulator_next;
  logic [SIZE_BITS-1:0] value_remaining, value_remaining_next;
  logic [SIZE_BITS-1:0] value_position, value_position_next;
  logic                 match_seen, match_seen_next;
  status_t              end_status, end_status_next;

  // Working values.
  phase_t               ph;
  logic [SIZE_BITS-1:0] off;
  logic [SIZE_BITS-1:0] off_inc;
  logic [SIZE_BITS-1:0] bytes_left;
  logic [31:0]          acc_sum;
  logic [31:0]          pos_wide;
  logic [7:0]           b;
  logic                 done;
  logic                 first;
  role_t                role;
  status_t              status;
  logic [7:0]           vbyte;
  logic [15:0]          vindex;

  // Next state and the result of one byte.
  always_comb begin
    b   = item.data_byte;
    // A buffer start clears the parse before the byte is used.
    if (item.start_of_buffer) begin
      ph                      = PH_TAG;
      off                     = '0;
      current_tag_next        = '0;
      length_accumulator_next = '0;
      value_remaining_next    = '0;
      value_position_next     = '0;
      match_seen_next         = 1'b0;
      end_status_next         = ST_BUSY;
    end else begin
      ph                      = parse_phase;
      off                     = byte_offset;
      current_tag_next        = current_tag;
      length_accumulator_next = length_accumulator;
      value_remaining_next    = value_remaining;
      value_position_next     = value_position;
      match_seen_next         = match_seen;
      end_status_next         = end_status;
    end
    parse_phase_next = ph;
    byte_offset_next = off;
    off_inc          = off + SIZE_BITS'(1);
    bytes_left       = (buffer_size > off_inc) ? (buffer_size - off_inc) : '0;
    acc_sum          = length_accumulator_next + {24'b0, b & LEN_DATA_MASK};
    pos_wide         = 32'(value_position_next);
    role             = ROLE_IGNORED;
    status           = ST_BUSY;
    vbyte            = '0;
    vindex           = '0;
    done             = 1'b0;
    first            = 1'b0;

    case (ph)
      PH_DONE: begin
        status = end_status_next;
      end
      PH_TAG: begin
        if (off >= buffer_size) begin
          // Byte beyond the buffer end.
          status           = ST_END;
          end_status_next  = ST_END;
          parse_phase_next = PH_DONE;
        end else begin
          current_tag_next        = b;
          length_accumulator_next = '0;
          value_position_next     = '0;
          value_remaining_next    = '0;
          byte_offset_next        = off_inc;
          role                    = ROLE_TAG;
          if (off_inc == buffer_size) begin
            // A tag as the last byte: zero padding, or a cut-off record.
            if (b == 8'd0) begin
              role   = ROLE_PAD;
              status = ST_PAD_END;
            end else begin
              status = ST_BAD_LEN;
            end
            end_status_next  = status;
            parse_phase_next = PH_DONE;
          end else begin
            parse_phase_next = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        role             = ROLE_LEN;
        byte_offset_next = off_inc;
        if ((b & LEN_MORE_BIT) != 8'd0) begin
          // Another length byte follows.
          length_accumulator_next = acc_sum << 7;
          if (off_inc >= buffer_size) begin
            status           = ST_BAD_LEN;
            end_status_next  = ST_BAD_LEN;
            parse_phase_next = PH_DONE;
          end
        end else begin
          length_accumulator_next = acc_sum;
          if (acc_sum > 32'(bytes_left)) begin
            status           = ST_OVERRUN;
            end_status_next  = ST_OVERRUN;
            parse_phase_next = PH_DONE;
          end else if (acc_sum == 32'd0) begin
            done = 1'b1;
          end else begin
            value_remaining_next = acc_sum[SIZE_BITS-1:0];
            value_position_next  = '0;
            parse_phase_next     = PH_VAL;
          end
        end
      end
      PH_VAL: begin
        role                 = ROLE_VALUE;
        vbyte                = b;
        vindex               = pos_wide[15:0];
        value_position_next  = value_position_next + SIZE_BITS'(1);
        value_remaining_next = value_remaining_next - SIZE_BITS'(1);
        byte_offset_next     = off_inc;
        done                 = (value_remaining_next == '0);
      end
      default: begin
        status = end_status_next;
      end
    endcase

    // Record completion: first-match flag and end of buffer.
    if (done) begin
      if (current_tag_next == match_tag && !match_seen_next) begin
        first           = 1'b1;
        match_seen_next = 1'b1;
      end
      if (byte_offset_next >= buffer_size) begin
        status           = ST_END;
        end_status_next  = ST_END;
        parse_phase_next = PH_DONE;
      end else begin
        parse_phase_next = PH_TAG;
      end
    end

    result.byte_role       = role;
    result.record_tag      = current_tag_next;
    result.record_length   = length_accumulator_next;
    result.value_byte      = vbyte;
    result.value_index     = vindex;
    result.record_done     = done;
    result.first_match_res = first;
    result.parse_status    = status;
  end

  // State registers, updated once per processed byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase        <= PH_TAG;
      byte_offset        <= '0;
      current_tag        <= '0;
      length_accumulator <= '0;
      value_remaining    <= '0;
      value_position     <= '0;
      match_seen         <= 1'b0;
      end_status         <= ST_BUSY;
    end else if (step) begin
      parse_phase        <= parse_phase_next;
      byte_offset        <= byte_offset_next;
      current_tag        <= current_tag_next;
      length_accumulator <= length_accumulator_next;
      value_remaining    <= value_remaining_next;
      value_position     <= value_position_next;
      match_seen         <= match_seen_next;
      end_status         <= end_status_next;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tlvp_out_stage.sv @@
// Result register stage: holds a result item until the receiver takes it.
`default_nettype none

module tlvp_out_stage (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 load,
  input  tlvp_pkg::res_item_t load_item,
  output logic                advance_ok,
  output logic                res_valid,
  input  wire                 res_stall,
  output tlvp_pkg::res_item_t res_item
);
  import tlvp_pkg::*;

  // The register can take a new item when empty or being emptied.
  assign advance_ok = !res_valid || !res_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      res_item <= load_item;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tlv_varint_length_parser_top.sv @@
// Top level of the TLV parser with a big-endian varint length.
//
// Bytes of a buffer enter on the src channel (src_valid, src_stall, src_item),
// with start_of_buffer set on the first byte of each buffer. Every byte gives
// exactly one item on the res channel (res_valid, res_stall, res_item) with
// its role, the record's tag and length so far, value data and parse status.
// The buffer size and the tag to match are written on the cfg port while the
// block is idle; register 0 is buffer_size and register 1 is match_tag.
// Each byte passes an input register, one step of the parse logic and the
// result register; throughput is one byte per cycle while res_stall is low.
// Reset clears the parse state, the valid flags of both registers and the
// configuration.
// When the receiver stalls, the result stays on res_item, the input register
// still takes one more byte if it is empty, and src_stall is then high until
// the result is taken.
`default_nettype none

module tlv_varint_length_parser_top #(
  parameter int SIZE_BITS = tlvp_pkg::SIZE_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                src_valid,
  output logic                               src_stall,
  input  tlvp_pkg::src_item_t                src_item,
  output logic                               res_valid,
  input  wire                                res_stall,
  output tlvp_pkg::res_item_t                res_item,
  input  wire                                cfg_we,
  input  wire [tlvp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [tlvp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tlvp_pkg::*;

  logic [SIZE_BITS-1:0] buffer_size;
  logic [7:0]           match_tag;
  logic [31:0]          cfg_wide;
  logic                 step;
  logic                 advance_ok;
  src_item_t            held_item;
  res_item_t            step_result;

  assign cfg_wide = {16'b0, cfg_data};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size <= '0;
      match_tag   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUFFER_SIZE: buffer_size <= cfg_wide[SIZE_BITS-1:0];
        REG_MATCH_TAG:   match_tag   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input register.
  tlvp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_item   (src_item),
    .advance_ok (advance_ok),
    .step       (step),
    .held_item  (held_item)
  );

  // Parse logic and state.
  tlvp_parse_core #(
    .SIZE_BITS (SIZE_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .item        (held_item),
    .buffer_size (buffer_size),
    .match_tag   (match_tag),
    .result      (step_result)
  );

  // Result register.
  tlvp_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (step),
    .load_item  (step_result),
    .advance_ok (advance_ok),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
  );

endmodule

`default_nettype wire

@@ hw/rtl/tlvp_checker.sv @@
// Port-level checks of the TLV parser, bound to the top level.
`default_nettype none

module tlvp_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 res_valid,
  input wire                 res_stall,
  input tlvp_pkg::res_item_t res_item
);
  import tlvp_pkg::*;

  // A stalled result item holds.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("result item changed while stalled");

  // Value data appears only on value bytes.
  a_value_only: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.byte_role != ROLE_VALUE |->
      res_item.value_byte == 8'd0 && res_item.value_index == 16'd0)
    else $error("value data on a byte that is not a value byte");

  // Only a length or value byte completes a record.
  a_done_role: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.record_done |->
      res_item.byte_role == ROLE_LEN || res_item.byte_role == ROLE_VALUE)
    else $error("record completed on a wrong byte role");

  // A match is flagged only on a completed record.
  a_match_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.first_match_res |-> res_item.record_done)
    else $error("match flagged without a completed record");

  // A completed record can only end the parse normally.
  a_done_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.record_done |->
      res_item.parse_status == ST_BUSY || res_item.parse_status == ST_END)
    else $error("completed record with an error status");

endmodule

bind tlv_varint_length_parser_top tlvp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_item  (res_item)
);

`default_nettype wire
